/* rtl/lmr_pkg.sv */
package lmr_pkg;

  localparam int COORD_W = 6;
  localparam int COLOR_W = 8;
  localparam int INDEX_W = 12;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  // Grey level: (r+g+b)/3 as (sum * 683) >> 11, exact for sums up to 765
  localparam logic [9:0] GREY_MUL   = 10'd683;
  localparam int         GREY_SHIFT = 11;

  // Register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_SNAKE_VERTICAL   = 2'd0;
  localparam logic [1:0] REG_ROTATE_HALF_TURN = 2'd1;
  localparam logic [1:0] REG_MONO_MODE        = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic snake_vertical;
    logic rotate_half_turn;
    logic mono_mode;
  } cfg_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic step;
    logic flush;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic run_done;
    logic pend_valid;
    logic out_free;
  } sts_t;

endpackage

/* rtl/lmr_regs.sv */
module lmr_regs
  import lmr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];

  // Write one register; only bit 0 is kept, unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_SNAKE_VERTICAL:   cfg.snake_vertical   <= pwdata[0];
        REG_ROTATE_HALF_TURN: cfg.rotate_half_turn <= pwdata[0];
        REG_MONO_MODE:        cfg.mono_mode        <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_SNAKE_VERTICAL:   prdata[0] = cfg.snake_vertical;
      REG_ROTATE_HALF_TURN: prdata[0] = cfg.rotate_half_turn;
      REG_MONO_MODE:        prdata[0] = cfg.mono_mode;
      default:              prdata    = '0;
    endcase
  end

endmodule

/* rtl/lmr_ctrl.sv */
module lmr_ctrl
  import lmr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (sts.run_done) begin
          state_next = ST_FLUSH;
        end else if (sts.out_free) begin
          cmd.step = 1'b1;
        end
      end
      ST_FLUSH: begin
        if (!sts.pend_valid) begin
          state_next = ST_IDLE;
        end else if (sts.out_free) begin
          cmd.flush  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // No pixel may be left behind when a new request can enter
  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !sts.pend_valid)
    else $error("pending pixel left while idle");

endmodule

/* rtl/lmr_datapath.sv */
module lmr_datapath
  import lmr_pkg::*;
#(
  parameter int MATRIX_WIDTH  = 16,
  parameter int MATRIX_HEIGHT = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic [COORD_W-1:0] start_col,
  input  logic [COORD_W-1:0] start_row,
  input  logic [COORD_W-1:0] end_col,
  input  logic [COORD_W-1:0] end_row,
  input  logic [COLOR_W-1:0] red,
  input  logic [COLOR_W-1:0] green,
  input  logic [COLOR_W-1:0] blue,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [INDEX_W-1:0] pixel_index,
  output logic [COLOR_W-1:0] out_red,
  output logic [COLOR_W-1:0] out_green,
  output logic [COLOR_W-1:0] out_blue,
  output logic               last_pixel
);

  localparam logic [12:0] W_P  = 13'(MATRIX_WIDTH);
  localparam logic [12:0] H_P  = 13'(MATRIX_HEIGHT);
  localparam logic [12:0] AREA = 13'(MATRIX_WIDTH * MATRIX_HEIGHT);
  localparam logic [6:0]  W_C  = 7'(MATRIX_WIDTH);
  localparam logic [6:0]  H_C  = 7'(MATRIX_HEIGHT);

  // Line registers
  logic               major_is_row;
  logic [COORD_W-1:0] cur;
  logic [COORD_W-1:0] major_end;
  logic [COORD_W-1:0] minor_start;
  logic               minor_neg;
  logic [COORD_W-1:0] dminor;
  logic [COORD_W-1:0] dmajor;
  logic [COORD_W-1:0] quo;
  logic [COORD_W-1:0] rem;
  logic [COLOR_W-1:0] line_r;
  logic [COLOR_W-1:0] line_g;
  logic [COLOR_W-1:0] line_b;

  // Pending pixel (held back until the next one shows whether it is last)
  logic               pend_valid;
  logic [INDEX_W-1:0] pend_index;

  // Setup logic
  logic [COORD_W-1:0] adc;
  logic [COORD_W-1:0] adr;
  logic               ld_row_major;
  logic               ld_swap;
  logic [COORD_W-1:0] lo_col;
  logic [COORD_W-1:0] lo_row;
  logic [COORD_W-1:0] hi_col;
  logic [COORD_W-1:0] hi_row;
  logic [9:0]         rgb_sum;
  logic [19:0]        grey_prod;
  logic [COLOR_W-1:0] grey;

  // Step logic
  logic [COORD_W:0]   rem_sum;
  logic               rem_wrap;
  logic [COORD_W-1:0] minor;
  logic [COORD_W-1:0] cand_col;
  logic [COORD_W-1:0] cand_row;
  logic               cand_in;
  logic [12:0]        col13;
  logic [12:0]        row13;
  logic [12:0]        row_pos;
  logic [12:0]        col_pos;
  logic [12:0]        pos_raw;
  logic [12:0]        pos;
  logic               out_free;
  logic               push_pend;

  // Order endpoints so the dominant axis runs upward; also form the grey level
  always_comb begin
    adc          = (end_col >= start_col) ? end_col - start_col : start_col - end_col;
    adr          = (end_row >= start_row) ? end_row - start_row : start_row - end_row;
    ld_row_major = adr > adc;
    ld_swap      = ld_row_major ? (start_row > end_row) : (start_col > end_col);
    lo_col       = ld_swap ? end_col : start_col;
    lo_row       = ld_swap ? end_row : start_row;
    hi_col       = ld_swap ? start_col : end_col;
    hi_row       = ld_swap ? start_row : end_row;
    rgb_sum      = 10'(red) + 10'(green) + 10'(blue);
    grey_prod    = rgb_sum * GREY_MUL;
    grey         = grey_prod[GREY_SHIFT +: COLOR_W];
  end

  // Minor coordinate: quotient of offset*dminor/dmajor kept by running remainder
  always_comb begin
    rem_sum  = {1'b0, rem} + {1'b0, dminor};
    rem_wrap = rem_sum >= {1'b0, dmajor};
    minor    = minor_neg ? minor_start - quo : minor_start + quo;
    cand_col = major_is_row ? minor : cur;
    cand_row = major_is_row ? cur : minor;
    cand_in  = ({1'b0, cand_col} < W_C) && ({1'b0, cand_row} < H_C);
  end

  // Strip position of the candidate point
  always_comb begin
    col13   = {7'b0, cand_col};
    row13   = {7'b0, cand_row};
    row_pos = row13 * W_P + (cand_row[0] ? W_P - 13'd1 - col13 : col13);
    col_pos = cand_col[0] ? (col13 + 13'd1) * H_P - 13'd1 - row13 : col13 * H_P + row13;
    pos_raw = cfg.snake_vertical ? col_pos : row_pos;
    pos     = cfg.rotate_half_turn ? AREA - 13'd1 - pos_raw : pos_raw;
  end

  assign out_free  = !out_valid || out_ready;
  assign push_pend = cmd.step && cand_in && pend_valid;

  assign sts.run_done   = cur == major_end;
  assign sts.pend_valid = pend_valid;
  assign sts.out_free   = out_free;

  // Load the line, then advance one point per step
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      major_is_row <= ld_row_major;
      cur          <= ld_row_major ? lo_row : lo_col;
      major_end    <= ld_row_major ? hi_row : hi_col;
      minor_start  <= ld_row_major ? lo_col : lo_row;
      minor_neg    <= ld_row_major ? (hi_col < lo_col) : (hi_row < lo_row);
      dminor       <= ld_row_major ? adc : adr;
      dmajor       <= ld_row_major ? adr : adc;
      quo          <= '0;
      rem          <= '0;
      line_r       <= cfg.mono_mode ? grey : red;
      line_g       <= cfg.mono_mode ? grey : green;
      line_b       <= cfg.mono_mode ? grey : blue;
    end else if (cmd.step) begin
      cur <= cur + 1'b1;
      if (rem_wrap) begin
        rem <= COORD_W'(rem_sum - {1'b0, dmajor});
        quo <= quo + 1'b1;
      end else begin
        rem <= rem_sum[COORD_W-1:0];
      end
    end
  end

  // Hold the newest in-range point
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (cmd.step && cand_in) begin
      pend_valid <= 1'b1;
    end else if (cmd.flush || cmd.load) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && cand_in) begin
      pend_index <= pos[INDEX_W-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push_pend || cmd.flush) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_pend || cmd.flush) begin
      pixel_index <= pend_index;
      out_red     <= line_r;
      out_green   <= line_g;
      out_blue    <= line_b;
      last_pixel  <= cmd.flush;
    end
  end

  a_step_in_line: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> (cur != major_end))
    else $error("step past end of dominant axis");

  a_flush_has_pixel: assert property (@(posedge clk) disable iff (rst)
    cmd.flush |-> pend_valid)
    else $error("flush without pending pixel");

  a_last_alone: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_pixel) |-> !pend_valid)
    else $error("pixel pending behind final write");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.step) |-> (rem < dmajor))
    else $error("remainder out of range");

endmodule

/* rtl/led_matrix_line_rasterizer_top.sv */
// Flow: a request is accepted while idle, then the line advances one dominant-axis
// point per step (|dmajor| points), sees the end of the axis and releases the last
// pixel write. A new line is accepted only once the previous one is finished; the
// single running-remainder step unit yields one point per cycle while the output
// register is free (out_ready high or no write waiting).
// Reset: synchronous, active high; clears the control state, output valid and the
// configuration registers to 0. No memories, no clearing pass.
module led_matrix_line_rasterizer_top
  import lmr_pkg::*;
#(
  parameter int MATRIX_WIDTH  = 16,
  parameter int MATRIX_HEIGHT = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [COORD_W-1:0] start_col,
  input  logic [COORD_W-1:0] start_row,
  input  logic [COORD_W-1:0] end_col,
  input  logic [COORD_W-1:0] end_row,
  input  logic [COLOR_W-1:0] red,
  input  logic [COLOR_W-1:0] green,
  input  logic [COLOR_W-1:0] blue,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [INDEX_W-1:0] pixel_index,
  output logic [COLOR_W-1:0] out_red,
  output logic [COLOR_W-1:0] out_green,
  output logic [COLOR_W-1:0] out_blue,
  output logic               last_pixel
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  lmr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lmr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lmr_datapath #(
    .MATRIX_WIDTH  (MATRIX_WIDTH),
    .MATRIX_HEIGHT (MATRIX_HEIGHT)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd         (cmd),
    .sts         (sts),
    .start_col   (start_col),
    .start_row   (start_row),
    .end_col     (end_col),
    .end_row     (end_row),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pixel_index (pixel_index),
    .out_red     (out_red),
    .out_green   (out_green),
    .out_blue    (out_blue),
    .last_pixel  (last_pixel)
  );

endmodule
